### rtl/core/asymmetric_length_follower_assert.svh
// Assertion macros shared by the length follower RTL.
// Needs nothing else; include it before the module that asserts.
`ifndef ASYMMETRIC_LENGTH_FOLLOWER_ASSERT_SVH
`define ASYMMETRIC_LENGTH_FOLLOWER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define ALF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ALF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/alf_pkg.sv
// Shared widths, register codes, configuration struct and the 2^-f table
// for the length follower. No dependencies.
package alf_pkg;

    localparam int LEN_W        = 24;
    localparam int TIME_W       = 16;
    localparam int RATE_W       = 16;
    localparam int TOL_W        = 16;
    localparam int CFG_DATA_W   = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int MUL_W        = 32;
    localparam int PROD_W       = 2 * MUL_W;

    localparam int EXP_TABLE_BITS = 6;
    localparam int ROM_SIZE       = (1 << EXP_TABLE_BITS) + 1;
    localparam int IDX_W          = $clog2(ROM_SIZE);
    localparam int ROM_W          = 31;
    localparam int FRAC_BITS      = 24;
    localparam int REM_BITS       = FRAC_BITS - EXP_TABLE_BITS;
    localparam int Y_W            = 33;
    localparam int K_W            = Y_W - FRAC_BITS;
    localparam int E_W            = 17;

    localparam logic [30:0]      LOG2E_Q30 = 31'd1549082005;
    // From this exponent on the Q0.16 result rounds to zero
    localparam logic [K_W-1:0]   K_CUT     = K_W'(18);
    localparam logic [E_W-1:0]   E_ONE     = E_W'(65536);
    localparam logic [LEN_W-1:0] ARM_RESET = LEN_W'(32768);
    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(4);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ARM_LENGTH           = 2'd0,
        REG_MARGIN               = 2'd1,
        REG_SMOOTHING_RATE       = 2'd2,
        REG_COMPLETION_TOLERANCE = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [LEN_W-1:0]  arm_length;
        logic [LEN_W-1:0]  margin;
        logic [RATE_W-1:0] smoothing_rate;
        logic [TOL_W-1:0]  completion_tolerance;
    } cfg_t;

    typedef logic [ROM_W-1:0] rom_t [ROM_SIZE];

    function automatic logic [63:0] floor_sqrt(logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] res;
        logic [63:0] bit_w;
        v     = v_in;
        res   = '0;
        bit_w = 64'd1 << 62;
        for (int s = 0; s < 32; s++) begin
            if (bit_w > v) begin
                bit_w = bit_w >> 2;
            end
        end
        for (int s = 0; s < 32; s++) begin
            if (bit_w != '0) begin
                if (v >= res + bit_w) begin
                    v   = v - (res + bit_w);
                    res = (res >> 1) + bit_w;
                end else begin
                    res = res >> 1;
                end
                bit_w = bit_w >> 2;
            end
        end
        return res;
    endfunction

    // 2^-(j / 2^EXP_TABLE_BITS) in Q0.30, built by repeated square roots
    function automatic rom_t build_rom();
        rom_t        tab;
        logic [63:0] q;
        logic [63:0] prod;
        q = 64'd1 << 29;
        for (int n = 0; n < EXP_TABLE_BITS; n++) begin
            q = floor_sqrt(q << 30);
        end
        tab[0] = ROM_W'(64'd1 << 30);
        for (int n = 1; n < ROM_SIZE; n++) begin
            prod   = (64'(tab[n-1]) * q + (64'd1 << 29)) >> 30;
            tab[n] = ROM_W'(prod);
        end
        return tab;
    endfunction

    localparam rom_t EXP_ROM = build_rom();

endpackage

### rtl/core/alf_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
// Depends on alf_pkg for operand and product widths.
module alf_mul (
    input  logic                        clk,
    input  logic [alf_pkg::MUL_W-1:0]   a,
    input  logic [alf_pkg::MUL_W-1:0]   b,
    output logic [alf_pkg::PROD_W-1:0]  p
);
    import alf_pkg::*;

    logic [PROD_W-1:0] p_reg;
    logic [PROD_W-1:0] p_next;

    assign p_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk) begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

### rtl/core/alf_core.sv
// Sequencer and datapath of the length follower: target clamp, exp blend
// through the shared multiplier, kept length. Depends on alf_pkg, alf_mul.
`include "asymmetric_length_follower_assert.svh"

module alf_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  alf_pkg::cfg_t             cfg,
    input  logic                      reseed_en,
    input  logic [alf_pkg::LEN_W-1:0] reseed_val,
    input  logic                      start,
    input  logic                      in_hit_valid,
    input  logic [alf_pkg::LEN_W-1:0] in_hit_distance,
    input  logic [alf_pkg::TIME_W-1:0] in_tick_seconds,
    input  logic                      out_free,
    output logic                      idle,
    output logic                      done,
    output logic [alf_pkg::LEN_W-1:0] length_now,
    output logic [alf_pkg::LEN_W-1:0] target_length
);
    import alf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_TGT, S_MX, S_MY, S_KF, S_ROM, S_MD, S_M, S_E, S_MG, S_FIN, S_DONE
    } state_t;

    state_t                 state_reg,  state_next;
    logic                   hv_reg,     hv_next;
    logic [LEN_W-1:0]       dist_reg,   dist_next;
    logic [TIME_W-1:0]      dt_reg,     dt_next;
    logic [LEN_W-1:0]       tgt_reg,    tgt_next;
    logic [LEN_W-1:0]       cur_reg,    cur_next;
    logic [K_W-1:0]         k_reg,      k_next;
    logic [EXP_TABLE_BITS-1:0] idx_reg, idx_next;
    logic [REM_BITS-1:0]    rem_reg,    rem_next;
    logic [ROM_W-1:0]       t0_reg,     t0_next;
    logic [ROM_W-1:0]       d_reg,      d_next;
    logic [ROM_W-1:0]       m_reg,      m_next;
    logic [E_W-1:0]         blend_reg,  blend_next;

    logic [MUL_W-1:0]       mul_a;
    logic [MUL_W-1:0]       mul_b;
    logic [PROD_W-1:0]      mul_p;

    logic [LEN_W-1:0]       diff;
    logic [LEN_W-1:0]       tgt_w;
    logic [PROD_W-1:0]      ysum;
    logic [Y_W-1:0]         y_w;
    logic [IDX_W-1:0]       rom_lo_idx;
    logic [IDX_W-1:0]       rom_hi_idx;
    logic [PROD_W-1:0]      interp;
    logic [5:0]             k_sh;
    logic [32:0]            esum;
    logic [E_W-1:0]         e_w;
    logic [LEN_W-1:0]       gap;
    logic [PROD_W-1:0]      step_w;
    logic [LEN_W-1:0]       resolved;

    alf_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign diff       = (dist_reg > cfg.margin) ? (dist_reg - cfg.margin) : '0;
    assign tgt_w      = !hv_reg ? cfg.arm_length
                      : ((diff > cfg.arm_length) ? cfg.arm_length : diff);
    assign ysum       = mul_p + (64'd1 << 30 >> 1);
    assign y_w        = ysum[30 +: Y_W];
    assign rom_lo_idx = {1'b0, idx_reg};
    assign rom_hi_idx = rom_lo_idx + IDX_W'(1);
    assign interp     = (mul_p + (64'd1 << (REM_BITS - 1))) >> REM_BITS;
    assign k_sh       = {1'b0, k_reg[4:0]};
    assign esum       = 33'(m_reg) + (33'd1 << (k_sh + 6'd13));
    assign e_w        = (k_reg >= K_CUT) ? '0 : E_W'(esum >> (k_sh + 6'd14));
    assign gap        = tgt_reg - cur_reg;
    assign step_w     = (mul_p + 64'd32768) >> 16;

    always_comb begin
        state_next = state_reg;
        hv_next    = hv_reg;
        dist_next  = dist_reg;
        dt_next    = dt_reg;
        tgt_next   = tgt_reg;
        cur_next   = cur_reg;
        k_next     = k_reg;
        idx_next   = idx_reg;
        rem_next   = rem_reg;
        t0_next    = t0_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        blend_next = blend_reg;
        mul_a      = '0;
        mul_b      = '0;
        resolved   = cur_reg + step_w[LEN_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (start) begin
                    hv_next    = in_hit_valid;
                    dist_next  = in_hit_distance;
                    dt_next    = in_tick_seconds;
                    state_next = S_TGT;
                end
            end
            S_TGT: begin
                tgt_next = tgt_w;
                if (dt_reg == '0) begin
                    state_next = S_DONE;
                end else if (tgt_w <= cur_reg || cfg.smoothing_rate == '0) begin
                    // retract or no smoothing: snap to the target
                    cur_next   = tgt_w;
                    state_next = S_DONE;
                end else begin
                    state_next = S_MX;
                end
            end
            S_MX: begin
                mul_a      = MUL_W'(cfg.smoothing_rate);
                mul_b      = MUL_W'(dt_reg);
                state_next = S_MY;
            end
            S_MY: begin
                mul_a      = mul_p[MUL_W-1:0];
                mul_b      = MUL_W'(LOG2E_Q30);
                state_next = S_KF;
            end
            S_KF: begin
                k_next     = y_w[Y_W-1:FRAC_BITS];
                idx_next   = y_w[FRAC_BITS-1:REM_BITS];
                rem_next   = y_w[REM_BITS-1:0];
                state_next = S_ROM;
            end
            S_ROM: begin
                t0_next    = EXP_ROM[rom_lo_idx];
                d_next     = EXP_ROM[rom_lo_idx] - EXP_ROM[rom_hi_idx];
                state_next = S_MD;
            end
            S_MD: begin
                mul_a      = MUL_W'(d_reg);
                mul_b      = MUL_W'(rem_reg);
                state_next = S_M;
            end
            S_M: begin
                m_next     = t0_reg - interp[ROM_W-1:0];
                state_next = S_E;
            end
            S_E: begin
                blend_next = E_ONE - e_w;
                state_next = S_MG;
            end
            S_MG: begin
                mul_a      = MUL_W'(gap);
                mul_b      = MUL_W'(blend_reg);
                state_next = S_FIN;
            end
            S_FIN: begin
                // close enough: finish the extension
                if ((tgt_reg - resolved) <= LEN_W'(cfg.completion_tolerance)) begin
                    resolved = tgt_reg;
                end
                cur_next   = resolved;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (reseed_en && state_reg == S_IDLE) begin
            cur_next = reseed_val;
        end
    end

    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            cur_reg   <= ARM_RESET;
        end else begin
            state_reg <= state_next;
            cur_reg   <= cur_next;
        end
        hv_reg    <= hv_next;
        dist_reg  <= dist_next;
        dt_reg    <= dt_next;
        tgt_reg   <= tgt_next;
        k_reg     <= k_next;
        idx_reg   <= idx_next;
        rem_reg   <= rem_next;
        t0_reg    <= t0_next;
        d_reg     <= d_next;
        m_reg     <= m_next;
        blend_reg <= blend_next;
    end

    assign idle          = (state_reg == S_IDLE);
    assign done          = (state_reg == S_DONE) && out_free;
    assign length_now    = cur_reg;
    assign target_length = tgt_reg;

    `ALF_ASSERT_NEXT(a_start_seq, clk, rst_n, start, state_reg == S_TGT, "start did not enter target stage")
    `ALF_ASSERT_NOW(a_rise_only, clk, rst_n, state_reg == S_MG, tgt_reg > cur_reg, "blend entered without a rising target")
    `ALF_ASSERT_NOW(a_blend_range, clk, rst_n, state_reg == S_MG, blend_reg <= E_ONE, "blend factor above one")
    `ALF_ASSERT_NOW(a_no_overshoot, clk, rst_n, state_reg == S_DONE && dt_reg != '0, cur_reg <= tgt_reg, "length beyond target after a timed tick")

endmodule

### rtl/core/asymmetric_length_follower.sv
// A beat that snaps or holds the length goes from the target state straight
// to the done state; one that blends first passes the multiply and exponent
// states. The blend runs four passes through one shared 32x32 multiplier under
// the sequencer in alf_core; no new beat is taken until the core is idle.
// Reset (aresetn low, synchronous): configuration registers, core state and
// length return to their reset values; the result register empties.
// Top level of the length follower: configuration registers, result register.
// Depends on alf_pkg and alf_core.
module asymmetric_length_follower (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_hit_valid,
    input  logic [alf_pkg::LEN_W-1:0]       s_hit_distance,
    input  logic [alf_pkg::TIME_W-1:0]      s_tick_seconds,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [alf_pkg::LEN_W-1:0]       m_length_now,
    output logic [alf_pkg::LEN_W-1:0]       m_target_length,
    output logic                            m_at_target,
    input  logic                            cfg_we,
    input  logic [alf_pkg::CFG_IDX_W-1:0]   cfg_addr,
    input  logic [alf_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
    import alf_pkg::*;

    cfg_t             cfg_reg,      cfg_next;
    logic             m_valid_reg,  m_valid_next;
    logic [LEN_W-1:0] m_len_reg,    m_len_next;
    logic [LEN_W-1:0] m_tgt_reg,    m_tgt_next;
    logic             m_at_reg,     m_at_next;

    logic             core_idle;
    logic             core_done;
    logic             out_free;
    logic             reseed_en;
    logic [LEN_W-1:0] core_len;
    logic [LEN_W-1:0] core_tgt;

    assign out_free  = !m_valid_reg || m_ready;
    assign s_ready   = core_idle;
    assign reseed_en = cfg_we && (cfg_idx_t'(cfg_addr) == REG_ARM_LENGTH);

    alf_core u_core (
        .clk             (aclk),
        .rst_n           (aresetn),
        .cfg             (cfg_reg),
        .reseed_en       (reseed_en),
        .reseed_val      (cfg_wdata[LEN_W-1:0]),
        .start           (s_valid && core_idle),
        .in_hit_valid    (s_hit_valid),
        .in_hit_distance (s_hit_distance),
        .in_tick_seconds (s_tick_seconds),
        .out_free        (out_free),
        .idle            (core_idle),
        .done            (core_done),
        .length_now      (core_len),
        .target_length   (core_tgt)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                REG_ARM_LENGTH:           cfg_next.arm_length = cfg_wdata[LEN_W-1:0];
                REG_MARGIN:               cfg_next.margin = cfg_wdata[LEN_W-1:0];
                REG_SMOOTHING_RATE:       cfg_next.smoothing_rate = cfg_wdata[RATE_W-1:0];
                REG_COMPLETION_TOLERANCE: begin
                    cfg_next.completion_tolerance = cfg_wdata[TOL_W-1:0];
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    // Load a finished beat; drop the valid once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        m_len_next   = m_len_reg;
        m_tgt_next   = m_tgt_reg;
        m_at_next    = m_at_reg;
        if (core_done) begin
            m_valid_next = 1'b1;
            m_len_next   = core_len;
            m_tgt_next   = core_tgt;
            m_at_next    = (core_len == core_tgt);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.arm_length           <= ARM_RESET;
            cfg_reg.margin               <= '0;
            cfg_reg.smoothing_rate       <= '0;
            cfg_reg.completion_tolerance <= TOL_RESET;
            m_valid_reg                  <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            m_valid_reg <= m_valid_next;
        end
        m_len_reg <= m_len_next;
        m_tgt_reg <= m_tgt_next;
        m_at_reg  <= m_at_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_length_now    = m_len_reg;
    assign m_target_length = m_tgt_reg;
    assign m_at_target     = m_at_reg;

endmodule

### bench/asymmetric_length_follower_tb.sv
// Self-checking bench for the length follower: directed table, then random ticks.
// Depends on alf_pkg for widths, register codes and the configuration struct.
module asymmetric_length_follower_tb;
    import alf_pkg::*;

    localparam int SPLIT_BITS = FRAC_BITS - EXP_TABLE_BITS;
    localparam int SEGMENTS   = 8;
    localparam int SEG_TICKS  = 100;
    localparam int SHOW_MAX   = 40;

    typedef struct packed {
        logic [LEN_W-1:0] length_now;
        logic [LEN_W-1:0] target_length;
        logic             at_target;
    } follow_t;

    typedef struct packed {
        logic [2:0]        phase;
        logic              hit;
        logic [LEN_W-1:0]  hit_dist;
        logic [TIME_W-1:0] dt;
        logic              typed;
        follow_t           want;
    } tick_row_t;

    typedef struct packed {
        logic [3:0] mask;
        cfg_t       regs;
    } settings_t;

    // Register settings of the directed part; phase 0 runs on reset values
    localparam settings_t DIR_CFG [5] = '{
        '{4'b0000, '{ARM_RESET, 24'd0, 16'd0, TOL_RESET}},
        '{4'b1110, '{24'd0, 24'd4096, 16'h0100, 16'd4}},
        '{4'b1111, '{24'd0, 24'd0, 16'hFFFF, 16'hFFFF}},
        '{4'b1111, '{24'hFFFFFF, 24'hFFFFFF, 16'hFFFF, 16'd0}},
        '{4'b1110, '{24'd0, 24'd0, 16'd1, 16'd0}}
    };

    localparam tick_row_t DIR_ROWS [19] = '{
        // reset values: no smoothing, so every timed tick snaps
        '{3'd0, 1'b0, 24'd0,       16'd1,      1'b1, '{24'd32768, 24'd32768, 1'b1}},
        '{3'd0, 1'b1, 24'd0,       16'd1,      1'b1, '{24'd0, 24'd0, 1'b1}},
        '{3'd0, 1'b1, 24'hFFFFFF,  16'hFFFF,   1'b1, '{24'd32768, 24'd32768, 1'b1}},
        // zero tick keeps the length above the target
        '{3'd0, 1'b1, 24'd1000,    16'd0,      1'b1, '{24'd32768, 24'd1000, 1'b0}},
        '{3'd0, 1'b1, 24'd1000,    16'd1,      1'b1, '{24'd1000, 24'd1000, 1'b1}},
        // hit closer than the margin
        '{3'd1, 1'b1, 24'd100,     16'h8000,   1'b1, '{24'd0, 24'd0, 1'b1}},
        '{3'd1, 1'b0, 24'd0,       16'h8000,   1'b0, '0},
        '{3'd1, 1'b1, 24'h00AAAA,  16'h5555,   1'b0, '0},
        '{3'd1, 1'b0, 24'h000000,  16'hFFFF,   1'b0, '0},
        '{3'd1, 1'b1, 24'h555555,  16'hAAAA,   1'b0, '0},
        // zero reach
        '{3'd2, 1'b0, 24'd0,       16'd1,      1'b1, '{24'd0, 24'd0, 1'b1}},
        '{3'd2, 1'b1, 24'hFFFFFF,  16'hFFFF,   1'b1, '{24'd0, 24'd0, 1'b1}},
        // full reach, full margin, fastest rate, no tolerance
        '{3'd3, 1'b1, 24'hFFFFFF,  16'd1,      1'b1, '{24'd0, 24'd0, 1'b1}},
        '{3'd3, 1'b0, 24'd0,       16'd1,      1'b0, '0},
        '{3'd3, 1'b0, 24'd0,       16'hFFFF,   1'b0, '0},
        // slowest rate
        '{3'd4, 1'b1, 24'd0,       16'hFFFF,   1'b1, '{24'd0, 24'd0, 1'b1}},
        '{3'd4, 1'b0, 24'd0,       16'd1,      1'b0, '0},
        '{3'd4, 1'b0, 24'd0,       16'hFFFF,   1'b0, '0},
        '{3'd4, 1'b1, 24'h800000,  16'h1234,   1'b0, '0}
    };

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_hit_valid = 1'b0;
    logic [LEN_W-1:0]      s_hit_distance = '0;
    logic [TIME_W-1:0]     s_tick_seconds = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [LEN_W-1:0]      m_length_now;
    logic [LEN_W-1:0]      m_target_length;
    logic                  m_at_target;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    logic [ROM_W-1:0] pow_tab [ROM_SIZE];
    cfg_t             shadow_cfg = '{ARM_RESET, 24'd0, 16'd0, TOL_RESET};
    logic [LEN_W-1:0] kept_len = ARM_RESET;

    follow_t   follow_q [$];
    tick_row_t row_q [$];
    bit        idle_en = 1'b1;
    int        err_count = 0;
    int        ticks_taken = 0;
    int        blend_ticks = 0;
    int        held_ticks = 0;
    int        cfg_phases = 0;

    asymmetric_length_follower dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_hit_valid     (s_hit_valid),
        .s_hit_distance  (s_hit_distance),
        .s_tick_seconds  (s_tick_seconds),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_length_now    (m_length_now),
        .m_target_length (m_target_length),
        .m_at_target     (m_at_target),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] isqrt64(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // 2^-(j/64) in Q0.30 by repeated square roots of one half
    function automatic void fill_pow_tab();
        logic [63:0] root;
        logic [63:0] acc;
        root = 64'd1 << 29;
        for (int n = 0; n < EXP_TABLE_BITS; n++) begin
            root = isqrt64(root << 30);
        end
        acc = 64'd1 << 30;
        pow_tab[0] = ROM_W'(acc);
        for (int n = 1; n < ROM_SIZE; n++) begin
            acc = (acc * root + (64'd1 << 29)) >> 30;
            pow_tab[n] = ROM_W'(acc);
        end
    endfunction

    // exp(-x), x in Q8.24, as Q0.16 in 0..65536
    function automatic logic [63:0] decay_q16(logic [31:0] x);
        logic [63:0] y;
        logic [63:0] k;
        logic [63:0] frac;
        logic [63:0] slope;
        logic [63:0] m;
        int          idx;
        y = (64'(x) * 64'(LOG2E_Q30) + (64'd1 << 29)) >> 30;
        k = y >> FRAC_BITS;
        if (k > 64'd40) begin
            return '0;
        end
        frac  = y & ((64'd1 << FRAC_BITS) - 1);
        idx   = int'(frac >> SPLIT_BITS);
        frac  = frac & ((64'd1 << SPLIT_BITS) - 1);
        slope = 64'(pow_tab[idx]) - 64'(pow_tab[idx+1]);
        m     = 64'(pow_tab[idx])
                - ((slope * frac + (64'd1 << (SPLIT_BITS - 1))) >> SPLIT_BITS);
        return (m + (64'd1 << (k + 13))) >> (k + 14);
    endfunction

    function automatic follow_t advance_length(logic hit, logic [LEN_W-1:0] hit_dist,
                                               logic [TIME_W-1:0] dt);
        follow_t     res;
        logic [31:0] tgt;
        logic [31:0] nxt;
        logic [63:0] blend;
        logic [63:0] stride;
        if (!hit) begin
            tgt = 32'(shadow_cfg.arm_length);
        end else begin
            tgt = (hit_dist > shadow_cfg.margin) ? 32'(hit_dist - shadow_cfg.margin)
                                                 : 32'd0;
            if (tgt > 32'(shadow_cfg.arm_length)) begin
                tgt = 32'(shadow_cfg.arm_length);
            end
        end
        if (dt == '0) begin
            held_ticks++;
        end else if (tgt <= 32'(kept_len) || shadow_cfg.smoothing_rate == '0) begin
            kept_len = LEN_W'(tgt);
        end else begin
            blend_ticks++;
            blend  = 64'd65536 - decay_q16(32'(shadow_cfg.smoothing_rate) * 32'(dt));
            stride = (64'(tgt - 32'(kept_len)) * blend + 64'd32768) >> 16;
            nxt    = 32'(kept_len) + 32'(stride);
            if (tgt - nxt <= 32'(shadow_cfg.completion_tolerance)) begin
                nxt = tgt;
            end
            kept_len = LEN_W'(nxt);
        end
        res.length_now    = kept_len;
        res.target_length = LEN_W'(tgt);
        res.at_target     = (32'(kept_len) == tgt);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (err_count < SHOW_MAX) begin
            $display("[%0t] mismatch on %s: got %0h, want %0h", $realtime, what, got, want);
        end
        err_count++;
    endtask

    initial fill_pow_tab();

    always @(posedge aclk) begin : watch
        follow_t   want;
        tick_row_t row;
        if (aresetn) begin
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_addr))
                    REG_ARM_LENGTH: begin
                        shadow_cfg.arm_length = cfg_wdata;
                        kept_len = cfg_wdata;
                    end
                    REG_MARGIN:               shadow_cfg.margin = cfg_wdata;
                    REG_SMOOTHING_RATE:       shadow_cfg.smoothing_rate = RATE_W'(cfg_wdata);
                    REG_COMPLETION_TOLERANCE: shadow_cfg.completion_tolerance =
                                                  TOL_W'(cfg_wdata);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                row  = row_q.pop_front();
                want = advance_length(s_hit_valid, s_hit_distance, s_tick_seconds);
                if (row.typed) begin
                    want = row.want;
                end
                follow_q.push_back(want);
                ticks_taken++;
            end
            if (m_valid && m_ready) begin
                if (follow_q.size() == 0) begin
                    report_mismatch("unexpected result beat", 32'(m_length_now), '0);
                end else begin
                    want = follow_q.pop_front();
                    if (m_length_now !== want.length_now)
                        report_mismatch("length_now", 32'(m_length_now),
                                        32'(want.length_now));
                    if (m_target_length !== want.target_length)
                        report_mismatch("target_length", 32'(m_target_length),
                                        32'(want.target_length));
                    if (m_at_target !== want.at_target)
                        report_mismatch("at_target", 32'(m_at_target),
                                        32'(want.at_target));
                end
            end
        end
    end

    // Result side back-pressure: while idle_en is set, stall bursts between runs of ready
    initial begin : sink
        forever begin
            if (idle_en && $urandom_range(0, 2) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    end

    task automatic drive_tick(tick_row_t row);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        row_q.push_back(row);
        s_valid        <= 1'b1;
        s_hit_valid    <= row.hit;
        s_hit_distance <= row.hit_dist;
        s_tick_seconds <= row.dt;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic put_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    // Drain the pipe, then write the selected registers
    task automatic settle_and_write(settings_t st);
        s_valid <= 1'b0;
        while (follow_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (st.mask[REG_ARM_LENGTH])
            put_reg(REG_ARM_LENGTH, st.regs.arm_length);
        if (st.mask[REG_MARGIN])
            put_reg(REG_MARGIN, st.regs.margin);
        if (st.mask[REG_SMOOTHING_RATE])
            put_reg(REG_SMOOTHING_RATE, CFG_DATA_W'(st.regs.smoothing_rate));
        if (st.mask[REG_COMPLETION_TOLERANCE])
            put_reg(REG_COMPLETION_TOLERANCE, CFG_DATA_W'(st.regs.completion_tolerance));
        cfg_we <= 1'b0;
        @(posedge aclk);
        cfg_phases++;
    endtask

    function automatic settings_t rand_settings(bit all);
        settings_t st;
        st.mask = all ? 4'hF : 4'($urandom_range(1, 15));
        case ($urandom_range(0, 9))
            0:          st.regs.arm_length = 24'hFFFFFF;
            1:          st.regs.arm_length = 24'd1;
            2, 3, 4, 5: st.regs.arm_length = LEN_W'($urandom_range(1, 24'h03FFFF));
            default:    st.regs.arm_length = LEN_W'($urandom_range(1, 24'hFFFFFF));
        endcase
        case ($urandom_range(0, 3))
            0:       st.regs.margin = '0;
            1:       st.regs.margin = LEN_W'($urandom);
            default: st.regs.margin = LEN_W'($urandom_range(0, 24'h004000));
        endcase
        case ($urandom_range(0, 4))
            0:       st.regs.smoothing_rate = '0;
            1, 2:    st.regs.smoothing_rate = RATE_W'($urandom_range(16, 16'h0400));
            default: st.regs.smoothing_rate = RATE_W'($urandom);
        endcase
        case ($urandom_range(0, 2))
            0:       st.regs.completion_tolerance = TOL_W'($urandom_range(0, 16));
            1:       st.regs.completion_tolerance = TOL_W'($urandom_range(0, 16'h0400));
            default: st.regs.completion_tolerance = TOL_W'($urandom);
        endcase
        return st;
    endfunction

    // Mostly plausible hits around the reach, some raw noise
    function automatic tick_row_t rand_tick();
        tick_row_t   row;
        logic [31:0] lim;
        row     = '0;
        row.hit = ($urandom_range(0, 9) < 6);
        lim     = 32'(shadow_cfg.arm_length) + 32'(shadow_cfg.arm_length >> 2)
                  + 32'(shadow_cfg.margin);
        if (lim > 32'hFFFFFF) lim = 32'hFFFFFF;
        if ($urandom_range(0, 4) == 0)
            row.hit_dist = LEN_W'($urandom);
        else
            row.hit_dist = LEN_W'($urandom_range(0, lim));
        case ($urandom_range(0, 9))
            0:                row.dt = '0;
            1, 2, 3, 4, 5:    row.dt = TIME_W'($urandom_range(1, 16'h1000));
            default:          row.dt = TIME_W'($urandom);
        endcase
        return row;
    endfunction

    initial begin : stim
        int cur_phase;
        cur_phase = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIR_ROWS[i]) begin
            if (DIR_ROWS[i].phase != cur_phase) begin
                cur_phase = DIR_ROWS[i].phase;
                settle_and_write(DIR_CFG[cur_phase]);
            end
            drive_tick(DIR_ROWS[i]);
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            settle_and_write(rand_settings(seg == 0));
            idle_en = (seg < SEGMENTS - 1);
            for (int n = 0; n < SEG_TICKS; n++) begin
                if (seg == 3 && n == SEG_TICKS / 2) begin
                    // hold the sender until the pipe has emptied
                    s_valid <= 1'b0;
                    while (follow_q.size() != 0) @(posedge aclk);
                    @(posedge aclk);
                end
                drive_tick(rand_tick());
            end
        end

        s_valid <= 1'b0;
        while (follow_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("Ran %0d ticks under %0d register settings", ticks_taken, cfg_phases);
        $display("%0d ticks blended upward, %0d had zero elapsed time",
                 blend_ticks, held_ticks);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl/core
rtl/core/alf_pkg.sv
rtl/core/alf_mul.sv
rtl/core/alf_core.sv
rtl/core/asymmetric_length_follower.sv
bench/asymmetric_length_follower_tb.sv
